FILE: src/bls_pkg.sv
package bls_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int DATA_W    = 32;
	localparam int CAP_W     = 7;
	localparam int REQ_W     = 2;
	localparam int STATUS_W  = 2;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH = 2'd0,
		REQ_POP  = 2'd1,
		REQ_DUMP = 2'd2
	} req_t;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

	// what goes into the output register
	typedef enum logic [1:0] {
		OSEL_OK    = 2'd0,
		OSEL_OVF   = 2'd1,
		OSEL_UNF   = 2'd2,
		OSEL_RDATA = 2'd3
	} osel_t;

	typedef struct packed {
		logic  push_ok;
		logic  pop_rd;
		logic  dump_start;
		logic  dump_next;
		logic  out_load;
		osel_t out_sel;
		logic  out_last;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic ptr_zero;
		logic out_free;
	} sts_t;

endpackage

FILE: src/bls_ram.sv
module bls_ram
	#(
		parameter int WIDTH = 32,
		parameter int DEPTH = 64
	)
	(
		input  logic                     clk,
		input  logic                     we,
		input  logic [$clog2(DEPTH)-1:0] waddr,
		input  logic [WIDTH-1:0]         wdata,
		input  logic                     re,
		input  logic [$clog2(DEPTH)-1:0] raddr,
		output logic [WIDTH-1:0]         rdata
	);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/bls_ctrl.sv
module bls_ctrl
	import bls_pkg::*;
	(
		input  logic             clk,
		input  logic             arst_n,
		input  logic             in_valid,
		output logic             in_stall,
		input  logic [REQ_W-1:0] req_type,
		input  sts_t             sts,
		output cmd_t             cmd
	);

	typedef enum logic [2:0] {
		S_IDLE      = 3'b001,
		S_POP_WAIT  = 3'b010,
		S_DUMP_WAIT = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_stall = !((state_q == S_IDLE) && sts.out_free);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_t'(req_type))
						REQ_PUSH: begin
							cmd.out_load = 1'b1;
							cmd.out_last = 1'b1;
							cmd.out_sel  = sts.full ? OSEL_OVF : OSEL_OK;
							cmd.push_ok  = !sts.full;
						end
						REQ_POP: begin
							if (sts.empty) begin
								cmd.out_load = 1'b1;
								cmd.out_last = 1'b1;
								cmd.out_sel  = OSEL_UNF;
							end else begin
								cmd.pop_rd = 1'b1;
								state_d    = S_POP_WAIT;
							end
						end
						REQ_DUMP: begin
							if (sts.empty) begin
								cmd.out_load = 1'b1;
								cmd.out_last = 1'b1;
								cmd.out_sel  = OSEL_UNF;
							end else begin
								cmd.dump_start = 1'b1;
								state_d        = S_DUMP_WAIT;
							end
						end
						default: ;
					endcase
				end
			end
			S_POP_WAIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					cmd.out_sel  = OSEL_RDATA;
					state_d      = S_IDLE;
				end
			end
			S_DUMP_WAIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OSEL_RDATA;
					cmd.out_last = sts.ptr_zero;
					if (sts.ptr_zero) begin
						state_d = S_IDLE;
					end else begin
						cmd.dump_next = 1'b1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: src/bls_dp.sv
module bls_dp
	import bls_pkg::*;
	#(
		parameter int DEPTH = DEPTH_DEF
	)
	(
		input  logic                       clk,
		input  logic                       arst_n,
		input  logic                       cfg_valid,
		input  logic [CAP_W-1:0]           capacity,
		input  logic signed [DATA_W-1:0]   push_value,
		input  cmd_t                       cmd,
		output sts_t                       sts,
		output logic                       out_valid,
		input  logic                       out_stall,
		output logic signed [DATA_W-1:0]   data_out,
		output logic [STATUS_W-1:0]        status,
		output logic                       last
	);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [CAP_W-1:0]  cap_q;
	logic [CAP_W-1:0]  cap_eff;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     ptr_q;
	logic [AW-1:0]     top_addr;
	logic [AW-1:0]     raddr;
	logic              re;
	logic [DATA_W-1:0] rdata;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] data_q;
	logic [STATUS_W-1:0]      status_q;
	logic                     last_q;

	// capacity of zero behaves as one, anything above the store depth as the depth
	always_comb begin
		cap_eff = cap_q;
		if (cap_q == '0) begin
			cap_eff = CAP_W'(1);
		end else if (cap_q > CAP_W'(DEPTH)) begin
			cap_eff = CAP_W'(DEPTH);
		end
	end

	assign top_addr     = AW'(count_q - CW'(1));
	assign sts.empty    = (count_q == '0);
	assign sts.full     = (CAP_W'(count_q) >= cap_eff);
	assign sts.ptr_zero = (ptr_q == '0);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign re    = cmd.pop_rd || cmd.dump_start || cmd.dump_next;
	assign raddr = cmd.dump_next ? (ptr_q - AW'(1)) : top_addr;

	bls_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.push_ok),
		.waddr (AW'(count_q)),
		.wdata (push_value),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= capacity;
			end
			if (cmd.push_ok) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop_rd) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dump_start) begin
			ptr_q <= top_addr;
		end else if (cmd.dump_next) begin
			ptr_q <= ptr_q - AW'(1);
		end
		if (cmd.out_load) begin
			last_q <= cmd.out_last;
			case (cmd.out_sel)
				OSEL_OK: begin
					data_q   <= '0;
					status_q <= ST_OK;
				end
				OSEL_OVF: begin
					data_q   <= '0;
					status_q <= ST_OVERFLOW;
				end
				OSEL_UNF: begin
					data_q   <= '0;
					status_q <= ST_UNDERFLOW;
				end
				OSEL_RDATA: begin
					data_q   <= rdata;
					status_q <= ST_OK;
				end
				default: begin
					data_q   <= '0;
					status_q <= ST_OK;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_q;
	assign status    = status_q;
	assign last      = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond store depth");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_ok |-> !sts.full && !cmd.pop_rd)
		else $error("push written into a full stack");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_rd |=> count_q == $past(count_q) - CW'(1))
		else $error("pop did not remove the top entry");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register overwritten while held");

endmodule

FILE: src/bounded_lifo_stack_top.sv
// Push: output register loaded the cycle after acceptance; one push a cycle unless stalled.
// Pop: top entry read out of the registered store, then loaded once the output is free.
// Dump of N entries: top entry first, then one a cycle while the output is free.
// A new request is taken once the previous one's last result is loaded and the output is free.
// Reset clears the entry count and sets capacity to 64; store contents are not cleared.
module bounded_lifo_stack_top
	import bls_pkg::*;
	#(
		parameter int DEPTH = DEPTH_DEF
	)
	(
		input  logic                     clk,
		input  logic                     arst_n,
		input  logic                     in_valid,
		output logic                     in_stall,
		input  logic [REQ_W-1:0]         req_type,
		input  logic signed [DATA_W-1:0] push_value,
		output logic                     out_valid,
		input  logic                     out_stall,
		output logic signed [DATA_W-1:0] data_out,
		output logic [STATUS_W-1:0]      status,
		output logic                     last,
		input  logic                     cfg_valid,
		output logic                     cfg_ready,
		input  logic [CAP_W-1:0]         capacity
	);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	bls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	bls_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.capacity   (capacity),
		.push_value (push_value),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_out   (data_out),
		.status     (status),
		.last       (last)
	);

endmodule
